// ===== design/free_region_first_fit_search_macros.svh =====
`ifndef FREE_REGION_FIRST_FIT_SEARCH_MACROS_SVH
`define FREE_REGION_FIRST_FIT_SEARCH_MACROS_SVH

// Clocked property check on the block clock, held off during reset.
`define FRFFS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition that must never be true on a clock edge.
`define FRFFS_ASSERT_NEVER(label, expr, msg) \
   `FRFFS_ASSERT(label, !(expr), msg)

`endif

// ===== design/frffs_pkg.sv =====
`default_nettype none

package frffs_pkg;

   // Request kinds carried on the request tuser lane
   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_WRITE  = 2'd0;
   localparam opcode_type OP_QUERY  = 2'd1;
   localparam opcode_type OP_SEARCH = 2'd2;

   // Control register indexes
   typedef logic [0:0] reg_index_type;
   localparam reg_index_type REG_SEARCH_BASE  = 1'b0;
   localparam reg_index_type REG_SEARCH_LIMIT = 1'b1;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic write_slot;
      logic load;
      logic prep;
      logic scan_start;
      logic scan_step;
      logic eval;
      logic round;
      logic advance;
      logic emit;
   } dp_cmd_type;

   // Status from the datapath back to the sequencer
   typedef struct packed {
      logic is_search;
      logic past_limit;
      logic scan_done;
      logic hit_any;
      logic adv_fail;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/free_region_first_fit_search.sv =====
// Region table with overlap query and first-fit free range search.
// Request channel (req_*): one word per command; req_tuser carries the opcode
// (write slot, overlap query, find free region), req_tdata the operands.
// Response channel (rsp_*): one word for each query or search; slot writes
// and the undefined opcode give none.
// Control channel (csr_*): index 0 sets the search base, index 1 the search
// limit; it is always ready. The user must write it only while the block is
// idle; the block itself does not enforce this. With N table entries, a query
// scans the whole table once. A search scans the table for each candidate; a
// candidate hitting a used region moves the search on (at most N+1 of them),
// and it ends on a free candidate, a candidate at or past the limit, or
// a hit that leaves no further candidate in the address range.
// The table scan reads one entry per cycle from the region memory, and one
// command is in flight at a time; the next is taken the cycle after the
// result is loaded into the output register.
// Reset empties the table, sets base 0 and limit to the top address, and
// drops any pending response. If the receiver stalls, the result word holds
// in the output register; a new command is still accepted and its own result
// waits in the sequencer until the register frees up.
`default_nettype none

module free_region_first_fit_search #(
   parameter int TABLE_ENTRIES = 8,
   parameter int PAGE_BYTES    = 4096,
   parameter int ADDR_BITS     = 39
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // request: tdata = slot, slot_used, range_start, range_end, length
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [((3*ADDR_BITS+4+7)/8)*8-1:0]        req_tdata,
   // request: tuser = opcode
   input  frffs_pkg::opcode_type                     req_tuser,
   // response: tdata = overlaps, found, free_start
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [((ADDR_BITS+2+7)/8)*8-1:0]          rsp_tdata,
   // control registers
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  frffs_pkg::reg_index_type                  csr_index,
   input  logic [ADDR_BITS-1:0]                      csr_data
);
   import frffs_pkg::*;

   localparam int RSP_TW = ((ADDR_BITS + 2 + 7) / 8) * 8;

   logic [2:0]           req_slot;
   logic                 req_slot_used;
   logic [ADDR_BITS-1:0] req_range_start;
   logic [ADDR_BITS-1:0] req_range_end;
   logic [ADDR_BITS-1:0] req_length;
   logic                 rsp_overlaps;
   logic                 rsp_found;
   logic [ADDR_BITS-1:0] rsp_free_start;
   dp_cmd_type           cmd;
   dp_status_type        status;

   // Unpack the request word
   assign req_slot        = req_tdata[2:0];
   assign req_slot_used   = req_tdata[3];
   assign req_range_start = req_tdata[ADDR_BITS+3:4];
   assign req_range_end   = req_tdata[2*ADDR_BITS+3:ADDR_BITS+4];
   assign req_length      = req_tdata[3*ADDR_BITS+3:2*ADDR_BITS+4];

   // Pack the response word
   assign rsp_tdata = RSP_TW'({rsp_free_start, rsp_found, rsp_overlaps});

   frffs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   frffs_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .PAGE_BYTES    (PAGE_BYTES),
      .ADDR_BITS     (ADDR_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_opcode      (req_tuser),
      .req_slot        (req_slot),
      .req_slot_used   (req_slot_used),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .req_length      (req_length),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_overlaps    (rsp_overlaps),
      .rsp_found       (rsp_found),
      .rsp_free_start  (rsp_free_start),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

`default_nettype wire

// ===== design/frffs_dpath.sv =====
`default_nettype none

module frffs_dpath #(
   parameter int TABLE_ENTRIES = 8,
   parameter int PAGE_BYTES    = 4096,
   parameter int ADDR_BITS     = 39
) (
   input  logic                      clock,
   input  logic                      reset,
   // control register port
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  frffs_pkg::reg_index_type  csr_index,
   input  logic [ADDR_BITS-1:0]      csr_data,
   // request fields
   input  frffs_pkg::opcode_type     req_opcode,
   input  logic [2:0]                req_slot,
   input  logic                      req_slot_used,
   input  logic [ADDR_BITS-1:0]      req_range_start,
   input  logic [ADDR_BITS-1:0]      req_range_end,
   input  logic [ADDR_BITS-1:0]      req_length,
   // result word
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic                      rsp_overlaps,
   output logic                      rsp_found,
   output logic [ADDR_BITS-1:0]      rsp_free_start,
   // sequencer link
   input  frffs_pkg::dp_cmd_type     cmd,
   output frffs_pkg::dp_status_type  status
);
   import frffs_pkg::*;

   localparam int IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W      = $clog2(TABLE_ENTRIES + 2);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam logic [ADDR_BITS:0] PAGE_MASK = {(ADDR_BITS + 1){1'b1}} >>
      ((PAGE_SHIFT > ADDR_BITS) ? 0 : (ADDR_BITS + 1 - PAGE_SHIFT));
   localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] SCAN_READS = CNT_W'(TABLE_ENTRIES);

   // search window
   logic [ADDR_BITS-1:0] base_ff;
   logic [ADDR_BITS-1:0] limit_ff;

   // region table
   logic [ADDR_BITS-1:0] start_mem [TABLE_ENTRIES];
   logic [ADDR_BITS-1:0] end_mem   [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] used_ff;
   logic                 slot_ok;
   logic [IDX_W-1:0]     wr_addr;

   // current item
   logic                 is_search_ff;
   logic                 found_ff;
   logic [CNT_W-1:0]     iter_ff;
   logic [ADDR_BITS-1:0] cand_ff;
   logic [ADDR_BITS-1:0] len_ff;
   logic [ADDR_BITS-1:0] end_ff;
   logic [ADDR_BITS-1:0] end_in;
   logic [ADDR_BITS:0]   prep_sum;

   // scan pipeline
   logic [CNT_W-1:0]     scan_cnt_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 issue;
   logic                 rd_vld_ff;
   logic [ADDR_BITS-1:0] rd_start_ff;
   logic [ADDR_BITS-1:0] rd_end_ff;
   logic                 cmp_hit_ff;
   logic [ADDR_BITS-1:0] cmp_end_ff;
   logic                 any_ff;
   logic [ADDR_BITS-1:0] max_ff;

   // candidate step
   logic [ADDR_BITS-1:0] diff_ff;
   logic [ADDR_BITS:0]   diff_ext;
   logic [ADDR_BITS+1:0] up_sum;
   logic                 rem_nz;
   logic [ADDR_BITS-1:0] off_ff;
   logic [ADDR_BITS-1:0] off_in;
   logic                 round_fail_ff;
   logic                 round_fail_in;
   logic [ADDR_BITS:0]   adv_sum;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_overlaps_ff;
   logic                 rsp_found_ff;
   logic [ADDR_BITS-1:0] rsp_free_ff;

   // Take control writes at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         limit_ff <= '1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SEARCH_BASE:  base_ff  <= csr_data;
            REG_SEARCH_LIMIT: limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Write one table slot; slots past the table are dropped
   assign slot_ok = ({4'd0, req_slot} < 7'(TABLE_ENTRIES));
   assign wr_addr = IDX_W'(req_slot);
   assign rd_addr = scan_cnt_ff[IDX_W-1:0];
   assign issue   = cmd.scan_step & (scan_cnt_ff < SCAN_READS);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.write_slot && slot_ok) begin
         used_ff[wr_addr] <= req_slot_used;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_slot && slot_ok) begin
         start_mem[wr_addr] <= req_range_start;
         end_mem[wr_addr]   <= req_range_end;
      end
      if (issue) begin
         rd_start_ff <= start_mem[rd_addr];
         rd_end_ff   <= end_mem[rd_addr];
      end
   end

   // Saturating range end for the current candidate
   assign prep_sum = {1'b0, cand_ff} + {1'b0, len_ff};
   assign end_in   = prep_sum[ADDR_BITS] ? '1 : prep_sum[ADDR_BITS-1:0];

   // Round the jump distance up to a whole page
   assign diff_ext = {1'b0, diff_ff};
   assign rem_nz   = |(diff_ext & PAGE_MASK);
   assign up_sum   = {1'b0, diff_ext | PAGE_MASK} + (ADDR_BITS + 2)'(1);

   always_comb begin
      if (rem_nz) begin
         off_in        = up_sum[ADDR_BITS-1:0];
         round_fail_in = |up_sum[ADDR_BITS+1:ADDR_BITS];
      end else begin
         off_in        = diff_ff;
         round_fail_in = 1'b0;
      end
   end

   assign adv_sum = {1'b0, base_ff} + {1'b0, off_ff};

   // Item control state
   always_ff @(posedge clock) begin
      if (reset) begin
         is_search_ff  <= 1'b0;
         found_ff      <= 1'b0;
         iter_ff       <= '0;
         round_fail_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            is_search_ff <= (req_opcode == OP_SEARCH);
            found_ff     <= 1'b0;
            iter_ff      <= '0;
         end
         if (cmd.eval && !any_ff && is_search_ff) begin
            found_ff <= 1'b1;
         end
         if (cmd.round) begin
            round_fail_ff <= round_fail_in;
         end
         if (cmd.advance) begin
            iter_ff <= iter_ff + CNT_W'(1);
         end
      end
   end

   // Item payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cand_ff <= (req_opcode == OP_SEARCH) ? base_ff : req_range_start;
         len_ff  <= req_length;
      end else if (cmd.advance) begin
         cand_ff <= adv_sum[ADDR_BITS-1:0];
      end
      if (cmd.prep) begin
         end_ff <= end_in;
      end
      if (cmd.eval) begin
         diff_ff <= max_ff - base_ff;
      end
      if (cmd.round) begin
         off_ff <= off_in;
      end
   end

   // Scan: read one entry a cycle, compare, then fold into hit and largest end
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         rd_vld_ff   <= 1'b0;
         cmp_hit_ff  <= 1'b0;
         any_ff      <= 1'b0;
      end else begin
         if (cmd.scan_start) begin
            scan_cnt_ff <= '0;
         end else if (cmd.scan_step && scan_cnt_ff != SCAN_LAST) begin
            scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
         end
         rd_vld_ff  <= issue & used_ff[rd_addr];
         cmp_hit_ff <= rd_vld_ff & !(end_ff <= rd_start_ff || cand_ff >= rd_end_ff);
         if (cmd.scan_start) begin
            any_ff <= 1'b0;
         end else if (cmp_hit_ff) begin
            any_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_end_ff <= rd_end_ff;
      if (cmd.scan_start) begin
         max_ff <= '0;
      end else if (cmp_hit_ff && (!any_ff || cmp_end_ff > max_ff)) begin
         max_ff <= cmp_end_ff;
      end
   end

   // Result register: hold until the word is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_overlaps_ff <= !is_search_ff & any_ff;
         rsp_found_ff    <= is_search_ff & found_ff;
         rsp_free_ff     <= (is_search_ff && found_ff) ? cand_ff : '0;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_overlaps   = rsp_overlaps_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_free_start = rsp_free_ff;

   // Status to the sequencer
   always_comb begin
      status            = '0;
      status.is_search  = is_search_ff;
      status.past_limit = is_search_ff & (cand_ff >= limit_ff);
      status.scan_done  = (scan_cnt_ff == SCAN_LAST);
      status.hit_any    = any_ff;
      status.adv_fail   = round_fail_ff | adv_sum[ADDR_BITS] | (iter_ff == ITER_LAST);
      status.out_free   = !rsp_valid_ff | rsp_tready;
   end

`include "free_region_first_fit_search_macros.svh"

   `FRFFS_ASSERT_NEVER(a_no_overwrite, cmd.emit && rsp_valid_ff && !rsp_tready, "result word overwritten before it was taken")
   `FRFFS_ASSERT(a_cand_rises, cmd.advance && !status.adv_fail |=> cand_ff > $past(cand_ff), "search candidate did not move upward")

endmodule

`default_nettype wire

// ===== design/frffs_ctrl.sv =====
`default_nettype none

module frffs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  frffs_pkg::opcode_type     req_opcode,
   input  frffs_pkg::dp_status_type  status,
   output frffs_pkg::dp_cmd_type     cmd
);
   import frffs_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_PREP    = 3'd1;
   localparam logic [2:0] ST_SCAN    = 3'd2;
   localparam logic [2:0] ST_EVAL    = 3'd3;
   localparam logic [2:0] ST_ROUND   = 3'd4;
   localparam logic [2:0] ST_ADVANCE = 3'd5;
   localparam logic [2:0] ST_EMIT    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   // Write a slot from idle, or sequence one item: prepare candidate, scan table, decide, step or emit
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_WRITE) begin
                  cmd.write_slot = 1'b1;
               end else if (req_opcode == OP_QUERY || req_opcode == OP_SEARCH) begin
                  cmd.load = 1'b1;
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            if (status.past_limit) begin
               state_in = ST_EMIT;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (!status.hit_any || !status.is_search) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = status.adv_fail ? ST_EMIT : ST_PREP;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`include "free_region_first_fit_search_macros.svh"

   `FRFFS_ASSERT(a_cmd_excl, $onehot0({cmd.write_slot, cmd.load, cmd.prep, cmd.scan_step, cmd.eval, cmd.round, cmd.advance, cmd.emit}), "more than one datapath step commanded")
   `FRFFS_ASSERT(a_scan_to_eval, state_ff == ST_SCAN && status.scan_done |=> state_ff == ST_EVAL, "table scan did not end in evaluation")

endmodule

`default_nettype wire
